FILE: rtl/jcvp_pkg.sv
// shared types and register indexes for the joystick cursor viewport pan block
package jcvp_pkg;

  localparam int READING_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MARGIN = 2'd2;

  localparam logic [9:0] REST_LEVEL_RST  = 10'd512;
  localparam logic [8:0] DEAD_ZONE_RST   = 9'd64;
  localparam logic [9:0] FAST_MARGIN_RST = 10'd350;

  // signed step of one axis: -5, -1, 0, 1 or 5
  localparam int STEP_W = 4;
  localparam logic signed [STEP_W-1:0] STEP_NONE     = 4'sd0;
  localparam logic signed [STEP_W-1:0] STEP_SLOW_POS = 4'sd1;
  localparam logic signed [STEP_W-1:0] STEP_SLOW_NEG = -4'sd1;
  localparam logic signed [STEP_W-1:0] STEP_FAST_POS = 4'sd5;
  localparam logic signed [STEP_W-1:0] STEP_FAST_NEG = -4'sd5;

  typedef struct packed {
    logic [9:0] rest_level;
    logic [8:0] dead_zone;
    logic [9:0] fast_margin;
  } jcvp_cfg_t;

  typedef struct packed {
    logic [9:0] horiz_reading;
    logic [9:0] vert_reading;
  } jcvp_in_t;

  typedef struct packed {
    logic [8:0]  cursor_x;
    logic [8:0]  cursor_y;
    logic [10:0] map_x;
    logic [10:0] map_y;
    logic        full_redraw;
    logic        patch_redraw;
    logic [8:0]  old_cursor_x;
    logic [8:0]  old_cursor_y;
  } jcvp_out_t;

endpackage

FILE: rtl/jcvp_cfg_regs.sv
// configuration registers: rest reading, dead zone and fast step margin
module jcvp_cfg_regs
  import jcvp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output jcvp_cfg_t             cfg
);

  jcvp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_level  <= REST_LEVEL_RST;
      cfg_r.dead_zone   <= DEAD_ZONE_RST;
      cfg_r.fast_margin <= FAST_MARGIN_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_REST_LEVEL:  cfg_r.rest_level  <= wr_data;
        REG_DEAD_ZONE:   cfg_r.dead_zone   <= wr_data[8:0];
        REG_FAST_MARGIN: cfg_r.fast_margin <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/jcvp_axis.sv
// band classifier for one joystick axis, larger reading gives a positive step
module jcvp_axis
  import jcvp_pkg::*;
(
  input  logic [READING_W-1:0]     reading,
  input  jcvp_cfg_t                cfg,
  output logic signed [STEP_W-1:0] step
);

  localparam int BW = 13;

  logic signed [BW-1:0] r_s;
  logic signed [BW-1:0] lo_s;
  logic signed [BW-1:0] hi_s;
  logic signed [BW-1:0] lo_fast_s;
  logic signed [BW-1:0] hi_fast_s;

  always_comb begin
    r_s       = $signed({3'b000, reading});
    lo_s      = $signed({3'b000, cfg.rest_level}) - $signed({4'b0000, cfg.dead_zone});
    hi_s      = $signed({3'b000, cfg.rest_level}) + $signed({4'b0000, cfg.dead_zone});
    lo_fast_s = lo_s - $signed({3'b000, cfg.fast_margin});
    hi_fast_s = hi_s + $signed({3'b000, cfg.fast_margin});
    if (r_s < lo_s) begin
      step = (r_s > lo_fast_s) ? STEP_SLOW_NEG : STEP_FAST_NEG;
    end else if (r_s > hi_s) begin
      step = (r_s < hi_fast_s) ? STEP_SLOW_POS : STEP_FAST_POS;
    end else begin
      step = STEP_NONE;
    end
  end

endmodule

FILE: rtl/jcvp_pan.sv
// cursor and map window state with the combinational move, jump and clamp update
module jcvp_pan
  import jcvp_pkg::*;
#(
  parameter int VIEW_WIDTH   = 420,
  parameter int VIEW_HEIGHT  = 320,
  parameter int MAP_SIZE     = 2048,
  parameter int CURSOR_WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  logic signed [STEP_W-1:0] step_x,
  input  logic signed [STEP_W-1:0] step_y,
  output jcvp_out_t                res
);

  localparam int SW_RAW = $clog2(MAP_SIZE + VIEW_WIDTH + VIEW_HEIGHT + 16) + 1;
  localparam int SW     = (SW_RAW < 12) ? 12 : SW_RAW;
  localparam int COL_W  = $clog2(VIEW_WIDTH);
  localparam int ROW_W  = $clog2(VIEW_HEIGHT);
  localparam int WIN_W  = $clog2(MAP_SIZE);
  localparam int HALF   = CURSOR_WIDTH / 2;

  localparam int WL_MAX = MAP_SIZE - VIEW_WIDTH;
  localparam int WT_MAX = MAP_SIZE - VIEW_HEIGHT;
  localparam int WL_C   = MAP_SIZE / 2 - VIEW_WIDTH / 2;
  localparam int WT_C   = MAP_SIZE / 2 - VIEW_HEIGHT / 2;
  localparam int WL_RST = (WL_C > WL_MAX) ? ((WL_MAX < 0) ? 0 : WL_MAX) : WL_C;
  localparam int WT_RST = (WT_C > WT_MAX) ? ((WT_MAX < 0) ? 0 : WT_MAX) : WT_C;

  localparam logic signed [SW-1:0] HALF_S   = SW'(HALF);
  localparam logic signed [SW-1:0] ZERO_S   = SW'(0);
  localparam logic signed [SW-1:0] VW_S     = SW'(VIEW_WIDTH);
  localparam logic signed [SW-1:0] VH_S     = SW'(VIEW_HEIGHT);
  localparam logic signed [SW-1:0] WL_MAX_S = SW'(WL_MAX);
  localparam logic signed [SW-1:0] WT_MAX_S = SW'(WT_MAX);
  localparam logic signed [SW-1:0] RIGHT_S  = SW'(VIEW_WIDTH - HALF);
  localparam logic signed [SW-1:0] BOTTOM_S = SW'(VIEW_HEIGHT - HALF);
  localparam logic signed [SW-1:0] COL_HI_S = SW'(VIEW_WIDTH - 1 - HALF);
  localparam logic signed [SW-1:0] ROW_HI_S = SW'(VIEW_HEIGHT - 1 - HALF);
  localparam logic signed [SW-1:0] COL_MID_S = SW'(VIEW_WIDTH / 2);
  localparam logic signed [SW-1:0] ROW_MID_S = SW'(VIEW_HEIGHT / 2);

  function automatic logic signed [SW-1:0] clamp_s(
    input logic signed [SW-1:0] v,
    input logic signed [SW-1:0] lo,
    input logic signed [SW-1:0] hi
  );
    logic signed [SW-1:0] t;
    t = (v > hi) ? hi : v;
    return (t < lo) ? lo : t;
  endfunction

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WIN_W-1:0] wl_r, wl_nxt;
  logic [WIN_W-1:0] wt_r, wt_nxt;

  logic signed [SW-1:0] col_e, row_e, wl_e, wt_e;
  logic signed [SW-1:0] cx, cy, wl_j, wt_j;
  logic signed [SW-1:0] col_new, row_new, wl_new, wt_new;
  logic                 jumped;

  always_comb begin
    col_e = $signed({{(SW-COL_W){1'b0}}, col_r});
    row_e = $signed({{(SW-ROW_W){1'b0}}, row_r});
    wl_e  = $signed({{(SW-WIN_W){1'b0}}, wl_r});
    wt_e  = $signed({{(SW-WIN_W){1'b0}}, wt_r});
    cx    = col_e - SW'(step_x);
    cy    = row_e + SW'(step_y);
    wl_j  = wl_e;
    wt_j  = wt_e;
    jumped = 1'b1;
    // edge priority: top, bottom, left, right
    if (cy < HALF_S && wt_e > ZERO_S) begin
      wt_j = wt_e - VH_S;
    end else if (cy > BOTTOM_S && wt_e < WT_MAX_S) begin
      wt_j = wt_e + VH_S;
    end else if (cx < HALF_S && wl_e > ZERO_S) begin
      wl_j = wl_e - VW_S;
    end else if (cx > RIGHT_S && wl_e < WL_MAX_S) begin
      wl_j = wl_e + VW_S;
    end else begin
      jumped = 1'b0;
    end
    if (jumped) begin
      wl_new = clamp_s(wl_j, ZERO_S, WL_MAX_S);
      wt_new = clamp_s(wt_j, ZERO_S, WT_MAX_S);
      col_new = clamp_s(COL_MID_S, HALF_S, COL_HI_S);
      row_new = clamp_s(ROW_MID_S, HALF_S, ROW_HI_S);
    end else begin
      wl_new = wl_e;
      wt_new = wt_e;
      col_new = clamp_s(cx, HALF_S, COL_HI_S);
      row_new = clamp_s(cy, HALF_S, ROW_HI_S);
    end
    col_nxt = col_new[COL_W-1:0];
    row_nxt = row_new[ROW_W-1:0];
    wl_nxt  = wl_new[WIN_W-1:0];
    wt_nxt  = wt_new[WIN_W-1:0];

    res.cursor_x     = col_new[8:0];
    res.cursor_y     = row_new[8:0];
    res.map_x        = wl_new[10:0];
    res.map_y        = wt_new[10:0];
    res.full_redraw  = jumped;
    res.patch_redraw = (col_nxt != col_r) || (row_nxt != row_r);
    res.old_cursor_x = col_e[8:0];
    res.old_cursor_y = row_e[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= COL_W'(VIEW_WIDTH / 2);
      row_r <= ROW_W'(VIEW_HEIGHT / 2);
      wl_r  <= WIN_W'(WL_RST);
      wt_r  <= WIN_W'(WT_RST);
    end else if (step_en) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      wl_r  <= wl_nxt;
      wt_r  <= wt_nxt;
    end
  end

endmodule

FILE: rtl/joystick_cursor_viewport_pan.sv
// top level of the joystick cursor viewport pan block
// Each joystick sample yields exactly one result. A sample is captured in an
// input register; once the output register is free or being drained, the cursor
// and map window state is updated in a single pass (axis bands, edge jump,
// clamping) and the result is written to the output register. The block
// sustains one sample per cycle while out_ready stays high; the combinational
// state update loop sets that rate. Configuration writes are always taken
// (cfg_ready is high) and should only be issued while no transaction is in flight.
module joystick_cursor_viewport_pan
  import jcvp_pkg::*;
#(
  parameter int VIEW_WIDTH   = 420,
  parameter int VIEW_HEIGHT  = 320,
  parameter int MAP_SIZE     = 2048,
  parameter int CURSOR_WIDTH = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  jcvp_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output jcvp_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  jcvp_cfg_t cfg;
  jcvp_in_t  s1_data_r;
  jcvp_out_t res;
  jcvp_out_t out_data_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      adv;
  logic      in_fire;
  logic signed [STEP_W-1:0] step_x, step_y;

  assign cfg_ready = 1'b1;

  jcvp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  jcvp_axis u_axis_x (
    .reading (s1_data_r.horiz_reading),
    .cfg     (cfg),
    .step    (step_x)
  );

  jcvp_axis u_axis_y (
    .reading (s1_data_r.vert_reading),
    .cfg     (cfg),
    .step    (step_y)
  );

  jcvp_pan #(
    .VIEW_WIDTH   (VIEW_WIDTH),
    .VIEW_HEIGHT  (VIEW_HEIGHT),
    .MAP_SIZE     (MAP_SIZE),
    .CURSOR_WIDTH (CURSOR_WIDTH)
  ) u_pan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .step_x  (step_x),
    .step_y  (step_y),
    .res     (res)
  );

  // stage one moves on when the output register is free or being drained
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !adv);
    out_valid_nxt = adv || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: bench/tb_top.sv
// self-checking testbench for the joystick cursor viewport pan block
module tb_top
  import jcvp_pkg::*;
;

  localparam int VIEW_W = 420;
  localparam int VIEW_H = 320;
  localparam int MAP_SZ = 2048;
  localparam int CUR_W = 9;
  localparam int HALF_CUR = CUR_W / 2;
  localparam int SLOW_STEP = 1;
  localparam int FAST_STEP = 5;
  localparam int READING_MAX = 1023;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int DUT_LATENCY = 1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SWEEP_ITEMS = 1200;
  localparam int EXTREME_SETS = 6;
  localparam int EXT_CENTER [EXTREME_SETS] = '{0, 1023, 0, 1023, 512, 300};
  localparam int EXT_DEAD [EXTREME_SETS] = '{0, 511, 511, 0, 0, 20};
  localparam int EXT_MARGIN [EXTREME_SETS] = '{0, 1023, 0, 0, 1023, 100};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  jcvp_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  jcvp_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  jcvp_out_t expected_pan_q[$];
  int        errors;
  int        idle_cycles = 0;
  bit        src_gaps;
  bit        sink_stalls;

  // predictor copy of configuration and pan state
  int rest_level_m;
  int dead_zone_m;
  int fast_margin_m;
  int cur_col;
  int cur_row;
  int win_left;
  int win_top;

  joystick_cursor_viewport_pan #(
    .VIEW_WIDTH  (VIEW_W),
    .VIEW_HEIGHT (VIEW_H),
    .MAP_SIZE    (MAP_SZ),
    .CURSOR_WIDTH(CUR_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic void init_pan_model();
    rest_level_m = int'(REST_LEVEL_RST);
    dead_zone_m = int'(DEAD_ZONE_RST);
    fast_margin_m = int'(FAST_MARGIN_RST);
    cur_col = VIEW_W / 2;
    cur_row = VIEW_H / 2;
    win_left = clamp_int(MAP_SZ / 2 - VIEW_W / 2, 0, MAP_SZ - VIEW_W);
    win_top = clamp_int(MAP_SZ / 2 - VIEW_H / 2, 0, MAP_SZ - VIEW_H);
  endfunction

  // larger reading gives a positive step
  function automatic int band_step(int r);
    int lo;
    int hi;
    lo = rest_level_m - dead_zone_m;
    hi = rest_level_m + dead_zone_m;
    if (r < lo) return (r > lo - fast_margin_m) ? -SLOW_STEP : -FAST_STEP;
    if (r > hi) return (r < hi + fast_margin_m) ? SLOW_STEP : FAST_STEP;
    return 0;
  endfunction

  function automatic jcvp_out_t pan_predict(jcvp_in_t s);
    jcvp_out_t r;
    int        cx;
    int        cy;
    int        old_x;
    int        old_y;
    bit        jumped;
    old_x = cur_col;
    old_y = cur_row;
    cx = cur_col - band_step(int'(s.horiz_reading));
    cy = cur_row + band_step(int'(s.vert_reading));
    jumped = 1'b0;
    // edge priority: top, bottom, left, right
    if (cy < HALF_CUR && win_top > 0) begin
      win_top -= VIEW_H;
      jumped = 1'b1;
    end else if (cy > VIEW_H - HALF_CUR && win_top < MAP_SZ - VIEW_H) begin
      win_top += VIEW_H;
      jumped = 1'b1;
    end else if (cx < HALF_CUR && win_left > 0) begin
      win_left -= VIEW_W;
      jumped = 1'b1;
    end else if (cx > VIEW_W - HALF_CUR && win_left < MAP_SZ - VIEW_W) begin
      win_left += VIEW_W;
      jumped = 1'b1;
    end
    if (jumped) begin
      win_left = clamp_int(win_left, 0, MAP_SZ - VIEW_W);
      win_top = clamp_int(win_top, 0, MAP_SZ - VIEW_H);
      cx = VIEW_W / 2;
      cy = VIEW_H / 2;
    end
    cur_col = clamp_int(cx, HALF_CUR, VIEW_W - 1 - HALF_CUR);
    cur_row = clamp_int(cy, HALF_CUR, VIEW_H - 1 - HALF_CUR);
    r.cursor_x = 9'(cur_col);
    r.cursor_y = 9'(cur_row);
    r.map_x = 11'(win_left);
    r.map_y = 11'(win_top);
    r.full_redraw = jumped;
    r.patch_redraw = (old_x != cur_col) || (old_y != cur_row);
    r.old_cursor_x = 9'(old_x);
    r.old_cursor_y = 9'(old_y);
    return r;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endfunction

  function automatic void check_pan_result(jcvp_out_t got);
    jcvp_out_t want;
    if (expected_pan_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected result: cursor %0d,%0d map %0d,%0d",
                 got.cursor_x, got.cursor_y, got.map_x, got.map_y);
      return;
    end
    want = expected_pan_q.pop_front();
    if (got.cursor_x !== want.cursor_x)
      note_mismatch("cursor_x", want.cursor_x, got.cursor_x);
    if (got.cursor_y !== want.cursor_y)
      note_mismatch("cursor_y", want.cursor_y, got.cursor_y);
    if (got.map_x !== want.map_x)
      note_mismatch("map_x", want.map_x, got.map_x);
    if (got.map_y !== want.map_y)
      note_mismatch("map_y", want.map_y, got.map_y);
    if (got.full_redraw !== want.full_redraw)
      note_mismatch("full_redraw", want.full_redraw, got.full_redraw);
    if (got.patch_redraw !== want.patch_redraw)
      note_mismatch("patch_redraw", want.patch_redraw, got.patch_redraw);
    if (got.old_cursor_x !== want.old_cursor_x)
      note_mismatch("old_cursor_x", want.old_cursor_x, got.old_cursor_x);
    if (got.old_cursor_y !== want.old_cursor_y)
      note_mismatch("old_cursor_y", want.old_cursor_y, got.old_cursor_y);
  endfunction

  function automatic logic [READING_W-1:0] clip_reading(int r);
    return READING_W'(clamp_int(r, 0, READING_MAX));
  endfunction

  // dir: -1 below the dead zone, 0 inside it, +1 above it
  function automatic logic [READING_W-1:0] pick_reading(int dir, bit fast);
    int lo;
    int hi;
    int a;
    int b;
    lo = rest_level_m - dead_zone_m;
    hi = rest_level_m + dead_zone_m;
    if (dir < 0) begin
      a = fast ? 0 : lo - fast_margin_m + 1;
      b = fast ? lo - fast_margin_m : lo - 1;
    end else if (dir > 0) begin
      a = fast ? hi + fast_margin_m : hi + 1;
      b = fast ? READING_MAX : hi + fast_margin_m - 1;
    end else begin
      a = lo;
      b = hi;
    end
    if (a < 0) a = 0;
    if (b > READING_MAX) b = READING_MAX;
    if (a > b) return READING_W'($urandom_range(0, READING_MAX));
    return READING_W'($urandom_range(a, b));
  endfunction

  task automatic push_joystick_sample(input jcvp_in_t s);
    int gap;
    gap = src_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_pan_q.push_back(pan_predict(s));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pan_q.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_REST_LEVEL: rest_level_m = int'(val);
      REG_DEAD_ZONE: dead_zone_m = int'(val[8:0]);
      REG_FAST_MARGIN: fast_margin_m = int'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cfg(input int center, input int dead, input int margin);
    write_cfg_reg(REG_REST_LEVEL, CFG_DATA_W'(center));
    write_cfg_reg(REG_DEAD_ZONE, CFG_DATA_W'(dead));
    write_cfg_reg(REG_FAST_MARGIN, CFG_DATA_W'(margin));
  endtask

  // readings one either side of every band boundary, axes crossed
  task automatic probe_band_edges();
    int        lo;
    int        hi;
    int        pts [10];
    jcvp_in_t  s;
    lo = rest_level_m - dead_zone_m;
    hi = rest_level_m + dead_zone_m;
    pts = '{lo - fast_margin_m - 1, lo - fast_margin_m, lo - fast_margin_m + 1,
            lo - 1, lo, hi, hi + 1,
            hi + fast_margin_m - 1, hi + fast_margin_m, hi + fast_margin_m + 1};
    for (int i = 0; i < 10; i++) begin
      s.horiz_reading = clip_reading(pts[i]);
      s.vert_reading = clip_reading(pts[9 - i]);
      push_joystick_sample(s);
    end
  endtask

  // mostly held stick directions so the cursor reaches the edges, some noise
  task automatic drive_mixed(input int n);
    int       left;
    int       hold;
    int       hdir;
    int       vdir;
    bit       hfast;
    bit       vfast;
    jcvp_in_t s;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        s.horiz_reading = READING_W'($urandom_range(0, READING_MAX));
        s.vert_reading = READING_W'($urandom_range(0, READING_MAX));
        push_joystick_sample(s);
        left--;
      end else begin
        hold = $urandom_range(3, 60);
        hdir = int'($urandom_range(0, 2)) - 1;
        vdir = int'($urandom_range(0, 2)) - 1;
        hfast = $urandom_range(0, 3) != 0;
        vfast = $urandom_range(0, 3) != 0;
        for (int i = 0; i < hold && left > 0; i++) begin
          s.horiz_reading = pick_reading(hdir, hfast);
          s.vert_reading = pick_reading(vdir, vfast);
          push_joystick_sample(s);
          left--;
        end
      end
    end
  endtask

  task automatic test_band_edges();
    jcvp_in_t s;
    probe_band_edges();
    s = '{horiz_reading: 10'd0, vert_reading: 10'd0};
    push_joystick_sample(s);
    s = '{horiz_reading: 10'd0, vert_reading: 10'd1023};
    push_joystick_sample(s);
    s = '{horiz_reading: 10'd1023, vert_reading: 10'd0};
    push_joystick_sample(s);
    s = '{horiz_reading: 10'd1023, vert_reading: 10'd1023};
    push_joystick_sample(s);
    s = '{horiz_reading: 10'd512, vert_reading: 10'd512};
    push_joystick_sample(s);
    s = '{horiz_reading: 10'h2AA, vert_reading: 10'h155};
    push_joystick_sample(s);
    s = '{horiz_reading: 10'h155, vert_reading: 10'h2AA};
    push_joystick_sample(s);
  endtask

  task automatic test_register_writes();
    drain_results();
    // upper bit of dead_zone is dropped, unused index does nothing
    write_cfg_reg(REG_DEAD_ZONE, 10'h3FF);
    write_cfg_reg(REG_FAST_MARGIN, 10'd100);
    write_cfg_reg(REG_REST_LEVEL, 10'd700);
    write_cfg_reg(REG_NONE, 10'd5);
    probe_band_edges();
    drain_results();
    write_cfg_reg(REG_DEAD_ZONE, 10'h240);
    probe_band_edges();
  endtask

  task automatic test_config_extremes();
    for (int k = 0; k < EXTREME_SETS; k++) begin
      drain_results();
      load_cfg(EXT_CENTER[k], EXT_DEAD[k], EXT_MARGIN[k]);
      probe_band_edges();
      drive_mixed(30);
    end
  endtask

  task automatic test_pan_sweeps();
    int done_items;
    int seg;
    done_items = 0;
    while (done_items < SWEEP_ITEMS) begin
      drain_results();
      if ($urandom_range(0, 2) == 0)
        load_cfg($urandom_range(300, 700), $urandom_range(0, 150), $urandom_range(1, 400));
      else
        load_cfg(int'(REST_LEVEL_RST), int'(DEAD_ZONE_RST), int'(FAST_MARGIN_RST));
      src_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      seg = $urandom_range(60, 200);
      drive_mixed(seg);
      done_items += seg;
    end
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_pan_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    errors = 0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    init_pan_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_band_edges();
    test_register_writes();
    test_config_extremes();
    test_pan_sweeps();
    drain_results();
    repeat (2 * DUT_LATENCY) @(posedge clk);
    if (errors == 0 && expected_pan_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
